>>> design/lsas_pkg.sv
// Package for the LCG skip-ahead seed core: widths, generator constants,
// sequencer states, multiplier op tags and the structs passed between modules.
// No dependencies.
package lsas_pkg;

   // Field widths
   localparam int unsigned SEQ_INDEX_W = 63;
   localparam int unsigned SEED_W      = 64;
   localparam int unsigned TASK_W      = 16;
   localparam int unsigned CSR_IDX_W   = 8;
   localparam int unsigned HALF_W      = SEED_W / 2;
   localparam int unsigned PROD_W      = SEQ_INDEX_W + TASK_W;
   localparam int unsigned SUM_W       = PROD_W + 1;

   // Generator constants: x' = G*x + C mod 2^64
   localparam logic [SEED_W-1:0] LCG_MULT = 64'd2862933555777941757;
   localparam logic [SEED_W-1:0] LCG_INC  = 64'd12345;

   // Each index is scaled by 2^SKIP_SHIFT before the skip
   localparam int unsigned SKIP_SHIFT = 40;

   // Loop step counter: four issue slots, then drain steps for the multiplier
   localparam int unsigned STEP_W = 3;
   localparam logic [STEP_W-1:0] LAST_STEP = 3'd5;

   // Configuration register indexes
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_ROOT_SEED  = 8'd0,
      CSR_INTERLEAVE = 8'd1,
      CSR_TASK_COUNT = 8'd2,
      CSR_TASK_ID    = 8'd3
   } csr_idx_type;

   // Sequencer states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ILV_MUL,
      ST_ILV_ADD,
      ST_LOOP,
      ST_FIN_ISSUE,
      ST_FIN_WAIT,
      ST_DONE
   } state_type;

   // Multiplier op tags; the first four follow the loop issue order
   typedef enum logic [2:0] {
      OP_MULACC,
      OP_ADDACC,
      OP_CSTEP,
      OP_GSQ,
      OP_FINAL
   } mul_op_type;

   typedef struct packed {
      logic                  interleave_enable;
      logic [SEED_W-1:0]     root_seed;
      logic [TASK_W-1:0]     task_count;
      logic [TASK_W-1:0]     task_id;
   } cfg_type;

   typedef struct packed {
      logic              valid;
      mul_op_type        op;
      logic [SEED_W-1:0] a;
      logic [SEED_W-1:0] b;
   } mul_req_type;

   typedef struct packed {
      logic              valid;
      mul_op_type        op;
      logic [SEED_W-1:0] p;
   } mul_rsp_type;

   typedef struct packed {
      logic              valid;
      logic [SEED_W-1:0] seed;
      logic              overflow;
   } fin_type;

endpackage

>>> design/lsas_intf.sv
// Channel interfaces of the LCG skip-ahead seed core: request, response and
// configuration write. Depends on lsas_pkg.
interface lsas_req_if import lsas_pkg::*; ();
   logic                   valid;
   logic                   ready;
   logic [SEQ_INDEX_W-1:0] seq_index;

   modport source (output valid, output seq_index, input ready);
   modport sink   (input valid, input seq_index, output ready);
endinterface

interface lsas_rsp_if import lsas_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [SEED_W-1:0] seed;
   logic              overflow;

   modport source (output valid, output seed, output overflow, input ready);
   modport sink   (input valid, input seed, input overflow, output ready);
endinterface

interface lsas_csr_if import lsas_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [CSR_IDX_W-1:0] index;
   logic [SEED_W-1:0]    data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

>>> design/lsas_csr.sv
// Configuration registers of the LCG skip-ahead seed core.
// Depends on lsas_pkg and lsas_intf.
module lsas_csr import lsas_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   lsas_csr_if.sink   csr_chan,
   output cfg_type    cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   // Writes are always taken
   assign csr_chan.ready = 1'b1;

   // Register decode; unknown indexes are dropped
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_chan.valid) begin
         case (csr_chan.index)
            CSR_ROOT_SEED:  cfg_in.root_seed         = csr_chan.data;
            CSR_INTERLEAVE: cfg_in.interleave_enable = csr_chan.data[0];
            CSR_TASK_COUNT: cfg_in.task_count        = csr_chan.data[TASK_W-1:0];
            CSR_TASK_ID:    cfg_in.task_id           = csr_chan.data[TASK_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.root_seed         <= '0;
         cfg_ff.interleave_enable <= 1'b0;
         cfg_ff.task_count        <= TASK_W'(1);
         cfg_ff.task_id           <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

>>> design/lsas_mul64.sv
// Shared 64x64 multiplier, product modulo 2^64, two-stage pipeline built from
// three 32x32 partial products. Carries an op tag alongside. Depends on lsas_pkg.
module lsas_mul64 import lsas_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  mul_req_type mreq,
   output mul_rsp_type mrsp
);

   logic              v1_ff, v1_in;
   mul_op_type        op1_ff;
   logic [SEED_W-1:0] pp0_ff, pp0_in;
   logic [HALF_W-1:0] pp1_ff, pp1_in;
   logic [HALF_W-1:0] pp2_ff, pp2_in;
   logic              v2_ff;
   mul_op_type        op2_ff;
   logic [SEED_W-1:0] p_ff, p_in;
   logic [HALF_W-1:0] cross_sum;

   // Stage 1: low x low full product, cross terms keep only their low halves
   assign v1_in  = mreq.valid;
   assign pp0_in = SEED_W'(mreq.a[HALF_W-1:0]) * SEED_W'(mreq.b[HALF_W-1:0]);
   assign pp1_in = HALF_W'(mreq.a[HALF_W-1:0] * mreq.b[SEED_W-1:HALF_W]);
   assign pp2_in = HALF_W'(mreq.a[SEED_W-1:HALF_W] * mreq.b[HALF_W-1:0]);

   // Stage 2: fold the cross terms into the upper half
   assign cross_sum = pp1_ff + pp2_ff;
   assign p_in      = pp0_ff + {cross_sum, HALF_W'(0)};

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else begin
         v1_ff <= v1_in;
         v2_ff <= v1_ff;
      end
   end

   always_ff @(posedge clock) begin
      op1_ff <= mreq.op;
      pp0_ff <= pp0_in;
      pp1_ff <= pp1_in;
      pp2_ff <= pp2_in;
      op2_ff <= op1_ff;
      p_ff   <= p_in;
   end

   assign mrsp.valid = v2_ff;
   assign mrsp.op    = op2_ff;
   assign mrsp.p     = p_ff;

   // Every issued op comes out after both pipeline stages with its own tag
   a_mul_latency: assert property (@(posedge clock) disable iff (reset)
      mreq.valid |-> ##2 mrsp.valid)
      else $error("multiplier result missing two cycles after issue");

   a_mul_tag: assert property (@(posedge clock) disable iff (reset)
      mreq.valid |-> ##2 (mrsp.op == $past(mreq.op, 2)))
      else $error("multiplier tag changed in flight");

   a_mul_no_spurious: assert property (@(posedge clock) disable iff (reset)
      mrsp.valid |-> $past(mreq.valid, 2))
      else $error("multiplier result without an issue");

endmodule

>>> design/lsas_seq.sv
// Sequencer and datapath of the LCG skip-ahead seed core: interleave step,
// square-and-accumulate loop over the shared multiplier, final seed.
// Depends on lsas_pkg and lsas_intf.
module lsas_seq import lsas_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   lsas_req_if.sink    req_chan,
   input  cfg_type     cfg,
   output mul_req_type mreq,
   input  mul_rsp_type mrsp,
   output fin_type     fin,
   input  logic        fin_ready
);

   state_type         state_ff, state_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic [SEED_W-1:0] exp_ff, exp_in;
   logic [PROD_W-1:0] prod_ff, prod_in;
   logic [SEED_W-1:0] mul_acc_ff, mul_acc_in;
   logic [SEED_W-1:0] add_acc_ff, add_acc_in;
   logic [SEED_W-1:0] g_ff, g_in;
   logic [SEED_W-1:0] c_ff, c_in;
   logic [SEED_W-1:0] seed_ff, seed_in;
   logic              ovf_ff, ovf_in;
   logic [SUM_W-1:0]  ilv_sum;

   // Interleaved index plus task id, one bit of headroom for the carry
   assign ilv_sum = SUM_W'(prod_ff) + SUM_W'(cfg.task_id);

   // Next state, multiplier issue and writeback
   always_comb begin
      state_in   = state_ff;
      step_in    = step_ff;
      exp_in     = exp_ff;
      prod_in    = prod_ff;
      mul_acc_in = mul_acc_ff;
      add_acc_in = add_acc_ff;
      g_in       = g_ff;
      c_in       = c_ff;
      seed_in    = seed_ff;
      ovf_in     = ovf_ff;

      req_chan.ready = 1'b0;
      fin.valid      = 1'b0;
      fin.seed       = seed_ff;
      fin.overflow   = ovf_ff;
      mreq.valid     = 1'b0;
      mreq.op        = OP_MULACC;
      mreq.a         = mul_acc_ff;
      mreq.b         = g_ff;

      // Multiplier results land by tag
      if (mrsp.valid) begin
         case (mrsp.op)
            OP_MULACC: if (exp_ff[0]) mul_acc_in = mrsp.p;
            OP_ADDACC: if (exp_ff[0]) add_acc_in = mrsp.p + c_ff;
            OP_CSTEP:  c_in = mrsp.p;
            OP_GSQ:    g_in = mrsp.p;
            OP_FINAL: begin
               seed_in = mrsp.p + add_acc_ff;
               ovf_in  = 1'b0;
            end
            default: ;
         endcase
      end

      case (state_ff)
         ST_IDLE: begin
            req_chan.ready = 1'b1;
            if (req_chan.valid) begin
               g_in       = LCG_MULT;
               c_in       = LCG_INC;
               mul_acc_in = SEED_W'(1);
               add_acc_in = '0;
               step_in    = '0;
               if (cfg.interleave_enable) begin
                  exp_in   = SEED_W'(req_chan.seq_index);
                  state_in = ST_ILV_MUL;
               end else begin
                  exp_in   = SEED_W'(req_chan.seq_index) << SKIP_SHIFT;
                  state_in = ST_LOOP;
               end
            end
         end

         ST_ILV_MUL: begin
            prod_in  = PROD_W'(exp_ff[SEQ_INDEX_W-1:0]) * PROD_W'(cfg.task_count);
            state_in = ST_ILV_ADD;
         end

         ST_ILV_ADD: begin
            if (|ilv_sum[SUM_W-1:SEED_W]) begin
               seed_in  = '0;
               ovf_in   = 1'b1;
               state_in = ST_DONE;
            end else begin
               exp_in   = ilv_sum[SEED_W-1:0] << SKIP_SHIFT;
               state_in = ST_LOOP;
            end
         end

         // One exponent bit per pass: four issues, then drain steps
         ST_LOOP: begin
            if (step_ff == '0 && exp_ff == '0) begin
               state_in = ST_FIN_ISSUE;
            end else begin
               case (step_ff)
                  3'd0: begin
                     mreq.valid = 1'b1;
                     mreq.op    = OP_MULACC;
                     mreq.a     = mul_acc_ff;
                     mreq.b     = g_ff;
                  end
                  3'd1: begin
                     mreq.valid = 1'b1;
                     mreq.op    = OP_ADDACC;
                     mreq.a     = add_acc_ff;
                     mreq.b     = g_ff;
                  end
                  3'd2: begin
                     mreq.valid = 1'b1;
                     mreq.op    = OP_CSTEP;
                     mreq.a     = c_ff;
                     mreq.b     = g_ff + SEED_W'(1);
                  end
                  3'd3: begin
                     mreq.valid = 1'b1;
                     mreq.op    = OP_GSQ;
                     mreq.a     = g_ff;
                     mreq.b     = g_ff;
                  end
                  default: ;
               endcase
               if (step_ff == LAST_STEP) begin
                  exp_in  = exp_ff >> 1;
                  step_in = '0;
               end else begin
                  step_in = step_ff + STEP_W'(1);
               end
            end
         end

         // seed = root * mul_acc + add_acc
         ST_FIN_ISSUE: begin
            mreq.valid = 1'b1;
            mreq.op    = OP_FINAL;
            mreq.a     = cfg.root_seed;
            mreq.b     = mul_acc_ff;
            state_in   = ST_FIN_WAIT;
         end

         ST_FIN_WAIT: begin
            if (mrsp.valid) state_in = ST_DONE;
         end

         ST_DONE: begin
            fin.valid = 1'b1;
            if (fin_ready) state_in = ST_IDLE;
         end

         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         step_ff  <= '0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      exp_ff     <= exp_in;
      prod_ff    <= prod_in;
      mul_acc_ff <= mul_acc_in;
      add_acc_ff <= add_acc_in;
      g_ff       <= g_in;
      c_ff       <= c_in;
      seed_ff    <= seed_in;
      ovf_ff     <= ovf_in;
   end

   // Loop results only ever come back while the loop runs
   a_seq_loop_rsp: assert property (@(posedge clock) disable iff (reset)
      mrsp.valid && mrsp.op != OP_FINAL |-> state_ff == ST_LOOP)
      else $error("loop product arrived outside the loop");

   a_seq_step_range: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_LOOP |-> step_ff <= LAST_STEP)
      else $error("loop step counter out of range");

   a_seq_ovf_zero: assert property (@(posedge clock) disable iff (reset)
      fin.valid && fin.overflow |-> fin.seed == '0)
      else $error("overflowed result carries a nonzero seed");

   a_seq_final_done: assert property (@(posedge clock) disable iff (reset)
      mrsp.valid && mrsp.op == OP_FINAL |=> state_ff == ST_DONE)
      else $error("final product not followed by a result");

endmodule

>>> design/lcg_skip_ahead_seed_core.sv
// Top level of the LCG skip-ahead seed core: configuration registers,
// sequencer, shared multiplier and the response register.
// Depends on lsas_pkg, lsas_intf, lsas_csr, lsas_mul64 and lsas_seq.
//
//   Channel    Dir  Payload                         Handshake
//   req_chan   in   seq_index[62:0]                 valid/ready
//   rsp_chan   out  seed[63:0], overflow            valid/ready
//   csr_chan   in   index[7:0], data[63:0]          valid/ready, always ready
//
// One item at a time. From the accepting edge, an item passes the interleave
// multiply and add states when interleaving is on (an interleave overflow goes
// straight to the result), then one loop pass per bit of the shifted index (at
// most 64 bits), then the final product, before it loads the response register.
// Each index bit costs four products through the one shared two-stage
// 64-bit multiplier plus drain steps.
// A finished beat waits in the response register while the next item is taken.
// Reset is synchronous; configuration returns to its reset values.
module lcg_skip_ahead_seed_core import lsas_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   lsas_req_if.sink   req_chan,
   lsas_rsp_if.source rsp_chan,
   lsas_csr_if.sink   csr_chan
);

   cfg_type           cfg;
   mul_req_type       mreq;
   mul_rsp_type       mrsp;
   fin_type           fin;
   logic              fin_ready;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [SEED_W-1:0] rsp_seed_ff;
   logic              rsp_ovf_ff;

   lsas_csr u_csr (
      .clock    (clock),
      .reset    (reset),
      .csr_chan (csr_chan),
      .cfg      (cfg)
   );

   lsas_mul64 u_mul (
      .clock (clock),
      .reset (reset),
      .mreq  (mreq),
      .mrsp  (mrsp)
   );

   lsas_seq u_seq (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .cfg       (cfg),
      .mreq      (mreq),
      .mrsp      (mrsp),
      .fin       (fin),
      .fin_ready (fin_ready)
   );

   // Response register: loads when empty or being drained
   assign fin_ready = !rsp_valid_ff || rsp_chan.ready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (fin.valid && fin_ready) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (fin.valid && fin_ready) begin
         rsp_seed_ff <= fin.seed;
         rsp_ovf_ff  <= fin.overflow;
      end
   end

   assign rsp_chan.valid    = rsp_valid_ff;
   assign rsp_chan.seed     = rsp_seed_ff;
   assign rsp_chan.overflow = rsp_ovf_ff;

   // A handed-over result shows on the response channel next cycle
   a_top_load: assert property (@(posedge clock) disable iff (reset)
      fin.valid && fin_ready |=> rsp_chan.valid)
      else $error("finished result not loaded into response register");

   // No item finishes in the cycle right after it is taken
   a_top_latency: assert property (@(posedge clock) disable iff (reset)
      req_chan.valid && req_chan.ready |=> !fin.valid)
      else $error("result ready too early after accept");

   // A result held back by a full response register stays offered
   a_top_hold: assert property (@(posedge clock) disable iff (reset)
      fin.valid && !fin_ready |=> fin.valid && $stable(fin.seed))
      else $error("pending result dropped or changed");

endmodule
